FILE: src/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg: shared types, constants and helpers for the vertex transform
// Holds the number formats, the command codes, the matrix reset values and
// the saturation helper used by the transform datapath.
// ----------------------------------------------------------------------------
package vmt_pkg;

	// Number formats.
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IO_W        = 32;
	localparam int ENTRY_W     = 32;
	localparam int PROD_W      = 2 * ENTRY_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int NUM_PAIRS   = 8;
	localparam int NUM_ENTRIES = 2 * NUM_PAIRS;
	localparam int IDX_W       = $clog2(NUM_PAIRS);
	localparam int PAIR_W      = 2 * ENTRY_W;

	// Command codes. Code 3 has no name and runs as general mode.
	localparam logic [1:0] CMD_AFFINE      = 2'd0;
	localparam logic [1:0] CMD_PERSPECTIVE = 2'd1;
	localparam logic [1:0] CMD_GENERAL     = 2'd2;

	// Fixed-point constants.
	localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(longint'(1) << FRAC_BITS);
	localparam logic [ENTRY_W-1:0] MAT_MINUS_ONE =
		ENTRY_W'(longint'(0) - (longint'(1) << FRAC_BITS));
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		SUM_W'((longint'(1) << (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
	localparam logic [IO_W-1:0] OUT_MAX = SAT_MAX[IO_W-1:0];
	localparam logic [IO_W-1:0] OUT_MIN = SAT_MIN[IO_W-1:0];

	// Matrix register reset: the identity matrix.
	localparam logic [PAIR_W-1:0] PAIR_ONE_LO = PAIR_W'(longint'(1) << FRAC_BITS);
	localparam logic [PAIR_W-1:0] PAIR_ONE_HI = PAIR_ONE_LO << ENTRY_W;
	localparam logic [PAIR_W-1:0] PAIR_RESET [NUM_PAIRS] = '{
		PAIR_ONE_LO, '0, PAIR_ONE_HI, '0, '0, PAIR_ONE_LO, '0, PAIR_ONE_HI
	};

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic [IO_W-1:0] value;
		logic            clamped;
	} sat_res_t;

	// Sign-extends the low COORD_WIDTH bits of a coordinate port.
	function automatic entry_t sext_coord(input logic [IO_W-1:0] v);
		entry_t t;
		t = entry_t'(v << (IO_W - COORD_WIDTH));
		return t >>> (IO_W - COORD_WIDTH);
	endfunction

	// Clamps a wide value to COORD_WIDTH bits, returned sign-extended in IO_W.
	function automatic sat_res_t sat_coord(input sum_t v);
		sat_res_t r;
		if (v > SAT_MAX) begin
			r.value   = OUT_MAX;
			r.clamped = 1'b1;
		end else if (v < SAT_MIN) begin
			r.value   = OUT_MIN;
			r.clamped = 1'b1;
		end else begin
			r.value   = v[IO_W-1:0];
			r.clamped = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: src/vmt_dot4.sv
// ----------------------------------------------------------------------------
// vmt_dot4: four-term dot product lane
// Registers four full-width signed products and adds them exactly.
// ----------------------------------------------------------------------------
module vmt_dot4 import vmt_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  entry_t a [4],
	input  entry_t b [4],
	output sum_t   sum
);

	logic signed [PROD_W-1:0] prod_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= PROD_W'(a[k]) * PROD_W'(b[k]);
			end
		end
	end

	// The sum is exact; the products sign-extend into the wider width.
	assign sum = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1])
		+ SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]);

endmodule

FILE: src/vertex_matrix_transform.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform: 4x4 fixed-point vertex transform
// A request passes s1, s2 and the result register in turn before out_valid.
// One vertex per cycle while out_ready is high; each stage moves with the next.
// Reset loads the identity matrix and empties every pipeline stage.
// ----------------------------------------------------------------------------
module vertex_matrix_transform import vmt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Vertex request channel.
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [IO_W-1:0]     in_x,
	input  logic [IO_W-1:0]     in_y,
	input  logic [IO_W-1:0]     in_z,
	input  logic [IO_W-1:0]     in_w,
	input  logic                last_in,
	// Result channel.
	output logic                out_valid,
	input  logic                out_ready,
	output logic [IO_W-1:0]     out_x,
	output logic [IO_W-1:0]     out_y,
	output logic [IO_W-1:0]     out_z,
	output logic [IO_W-1:0]     out_w,
	output logic                perspective_ok,
	output logic                saturated,
	output logic                last_out,
	// Matrix configuration channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [PAIR_W-1:0]   cfg_data
);

	// The pipeline has three stages: an input register (s1), the product
	// registers inside the dot-product lanes (s2) and the result register.
	// Each stage moves forward when it is empty or when the stage after it
	// moves, so a bubble anywhere is filled even while the output stalls.

	logic [PAIR_W-1:0] mat_q [NUM_PAIRS];
	entry_t            m [NUM_ENTRIES];

	logic              v_s1, v_s2, out_valid_q;
	logic              en_s1, en_s2, en_out;

	logic [1:0]        cmd_s1, cmd_s2;
	entry_t            x_s1, y_s1, z_s1, w_s1, z_s2;
	logic              last_s1, last_s2;

	entry_t            op_a [4][4];
	entry_t            op_b [4][4];
	sum_t              dot [4];
	sum_t              res [4];
	sat_res_t          sat [4];
	logic              persp_form;

	logic [IO_W-1:0]   out_x_q, out_y_q, out_z_q, out_w_q;
	logic              persp_q, sat_q, last_q;

	// The configuration port never stalls. The user must write only while the
	// pipeline is empty, so no item sees a half-updated matrix (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PAIRS; k++) begin
				mat_q[k] <= PAIR_RESET[k];
			end
		end else if (cfg_valid && cfg_ready) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// Entry 2k is the low half of pair k and entry 2k+1 the high half.
	// The matrix is column major: entry i sits at row i%4, column i/4.
	always_comb begin
		for (int k = 0; k < NUM_PAIRS; k++) begin
			m[2*k]     = entry_t'(mat_q[k][ENTRY_W-1:0]);
			m[2*k + 1] = entry_t'(mat_q[k][PAIR_W-1:ENTRY_W]);
		end
	end

	// Stage enables, chained back from the result register.
	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// Input register. Coordinates keep only their low COORD_WIDTH bits.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1  <= command;
			x_s1    <= sext_coord(in_x);
			y_s1    <= sext_coord(in_y);
			z_s1    <= sext_coord(in_z);
			w_s1    <= sext_coord(in_w);
			last_s1 <= last_in;
		end
	end

	// Operand selection. Perspective mode uses two terms in rows 0 to 2,
	// with the other two forced to zero; the other modes multiply every row
	// by the vertex with w replaced by one.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < 4; k++) begin
				op_a[r][k] = m[r + 4*k];
			end
			op_b[r][0] = x_s1;
			op_b[r][1] = y_s1;
			op_b[r][2] = z_s1;
			op_b[r][3] = entry_t'(ONE_SUM[ENTRY_W-1:0]);
		end
		case (cmd_s1)
			CMD_PERSPECTIVE: begin
				op_a[0] = '{m[0], m[8], '0, '0};
				op_b[0] = '{x_s1, z_s1, '0, '0};
				op_a[1] = '{m[5], m[9], '0, '0};
				op_b[1] = '{y_s1, z_s1, '0, '0};
				op_a[2] = '{m[10], m[14], '0, '0};
				op_b[2] = '{z_s1, w_s1, '0, '0};
			end
			default: begin
			end
		endcase
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		vmt_dot4 u_dot4 (
			.clk (clk),
			.en  (en_s2),
			.a   (op_a[r]),
			.b   (op_b[r]),
			.sum (dot[r])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cmd_s2  <= cmd_s1;
			z_s2    <= z_s1;
			last_s2 <= last_s1;
		end
	end

	// Sums are truncated toward minus infinity by an arithmetic shift. The
	// w row is fixed at one in affine mode and is the negated z in
	// perspective mode; both pass through the same clamp as the others.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			res[r] = dot[r] >>> FRAC_BITS;
		end
		case (cmd_s2)
			CMD_AFFINE:      res[3] = ONE_SUM;
			CMD_PERSPECTIVE: res[3] = -SUM_W'(z_s2);
			default:         res[3] = dot[3] >>> FRAC_BITS;
		endcase
		for (int r = 0; r < 4; r++) begin
			sat[r] = sat_coord(res[r]);
		end
	end

	// The perspective-only form has zeros off the projection entries and
	// minus one in row 3 of column 2.
	assign persp_form = (mat_q[0][PAIR_W-1:ENTRY_W] == '0)
		&& (mat_q[1] == '0)
		&& (mat_q[2][ENTRY_W-1:0] == '0)
		&& (mat_q[3] == '0)
		&& (mat_q[5][PAIR_W-1:ENTRY_W] == MAT_MINUS_ONE)
		&& (mat_q[6] == '0)
		&& (mat_q[7][PAIR_W-1:ENTRY_W] == '0);

	// Result register. It holds while the consumer stalls, and the stages
	// behind it keep filling until they are full.
	always_ff @(posedge clk) begin
		if (en_out) begin
			out_x_q <= sat[0].value;
			out_y_q <= sat[1].value;
			out_z_q <= sat[2].value;
			out_w_q <= sat[3].value;
			persp_q <= persp_form;
			sat_q   <= sat[0].clamped || sat[1].clamped || sat[2].clamped
				|| sat[3].clamped;
			last_q  <= last_s2;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_x          = out_x_q;
	assign out_y          = out_y_q;
	assign out_z          = out_z_q;
	assign out_w          = out_w_q;
	assign perspective_ok = persp_q;
	assign saturated      = sat_q;
	assign last_out       = last_q;

`ifndef SYNTHESIS
	// With the result register empty, every stage can move, so a request
	// must be taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("in_ready low while the result register is empty");

	// An accepted request lands in the input stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request did not enter the input stage");

	// The saturation flag goes with at least one clamped coordinate.
	a_sat_has_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (out_x == OUT_MAX) || (out_x == OUT_MIN)
			|| (out_y == OUT_MAX) || (out_y == OUT_MIN)
			|| (out_z == OUT_MAX) || (out_z == OUT_MIN)
			|| (out_w == OUT_MAX) || (out_w == OUT_MIN))
		else $error("saturated set with no clamped coordinate");

	// The product stage keeps its item while the result register is full
	// and stalled.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && out_valid_q && !out_ready |=> v_s2)
		else $error("product stage lost an item during a stall");
`endif

endmodule
